[sv/bsa_pkg.sv]
// Shared constants for the bitmap slot allocator: table depth, field widths,
// command, status and register index codes. No dependencies.
`default_nettype none

package bsa_pkg;

   localparam int MAX_SLOTS = 256;
   localparam int IDX_W     = $clog2(MAX_SLOTS);
   localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
   localparam int WORD_W    = (MAX_SLOTS < 32) ? MAX_SLOTS : 32;
   localparam int NUM_WORDS = MAX_SLOTS / WORD_W;
   localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int BIT_W     = $clog2(WORD_W);

   localparam int ADDR_W    = 32;
   localparam int SIZE_W    = 16;
   localparam int COUNT_W   = 9;
   localparam int CMD_W     = 3;
   localparam int SIDX_W    = 8;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC_FIRST = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ALLOC_INDEX = 3'd2;
   localparam logic [CMD_W-1:0] CMD_QUERY       = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FREE_ADDR   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BUSY  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEMENT_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS_IN_USE = 2'd2;

endpackage

`default_nettype wire

[sv/bsa_divider.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on bsa_pkg for the address and element size widths.
`default_nettype none

module bsa_divider
   import bsa_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [ADDR_W-1:0] dividend,
   input  wire logic [SIZE_W-1:0] divisor,
   output logic                   done,
   output logic [ADDR_W-1:0]      quotient
);

   localparam int STEP_W = $clog2(ADDR_W);

   logic [SIZE_W-1:0] rem_ff;
   logic [ADDR_W-1:0] quo_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [SIZE_W:0]   shifted;
   logic [SIZE_W:0]   diff;
   logic              fits;

   assign shifted = {rem_ff, quo_ff[ADDR_W-1]};
   assign diff    = shifted - {1'b0, divisor};
   assign fits    = (shifted >= {1'b0, divisor});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(ADDR_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
         quo_ff <= {quo_ff[ADDR_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

[sv/bitmap_slot_allocator_core.sv]
// Top level of the bitmap slot allocator: command sequencer, occupancy memory
// and result register. Depends on bsa_pkg and bsa_divider.
//
// The occupancy bitmap sits in a synchronous memory of MAX_SLOTS/32 words of
// 32 bits, read through a registered port and written back after the modify
// step; a per-word valid bit makes reset and the clear command take effect at
// once. One transaction is in work at a time; a finished result waits in the
// output register while the next request is taken. Clear and unknown commands
// go straight to the result, query reads and checks one word, allocate-by-index
// adds the multiply and add for the address, allocate-first-free scans word by
// word, and free-by-address first runs the bit-serial offset/size division.
`default_nettype none

module bitmap_slot_allocator_core
   import bsa_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [CMD_W-1:0]     req_cmd,
   input  wire logic [SIDX_W-1:0]    req_slot_index,
   input  wire logic [ADDR_W-1:0]    req_element_address,

   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic                      rsp_slot_taken,
   output logic [SIDX_W-1:0]         rsp_granted_index,
   output logic [ADDR_W-1:0]         rsp_granted_address,

   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [ADDR_W-1:0]    csr_write_data
);

   localparam int PROD_W = IDX_W + SIZE_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_READ,
      S_CHECK,
      S_MUL,
      S_ADD,
      S_DONE
   } state_type;

   state_type             state_ff;
   logic [CMD_W-1:0]      cmd_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [WADDR_W-1:0]    word_ff;
   logic [STATUS_W-1:0]   status_ff;
   logic                  taken_ff;
   logic [IDX_W-1:0]      gidx_ff;
   logic [ADDR_W-1:0]     gaddr_ff;
   logic [PROD_W-1:0]     prod_ff;

   logic [ADDR_W-1:0]     base_ff;
   logic [SIZE_W-1:0]     size_ff;
   logic [COUNT_W-1:0]    slots_ff;

   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic                  rsp_taken_ff;
   logic [SIDX_W-1:0]     rsp_gidx_ff;
   logic [ADDR_W-1:0]     rsp_gaddr_ff;

   logic [WORD_W-1:0]     mem [NUM_WORDS];
   logic [WORD_W-1:0]     rd_data_ff;
   logic                  rd_valid_ff;
   logic [NUM_WORDS-1:0]  row_valid_ff;

   logic [CNT_W-1:0]      count;
   logic                  accept;
   logic                  div_start;
   logic                  div_done;
   logic [ADDR_W-1:0]     div_quotient;
   logic                  mem_re;
   logic                  mem_we;
   logic [WORD_W-1:0]     mem_wdata;
   logic                  clear_all;
   logic [WORD_W-1:0]     cur_word;
   logic [WORD_W-1:0]     free_bits;
   logic                  free_found;
   logic [BIT_W-1:0]      free_pos;
   logic [BIT_W-1:0]      bit_sel;
   logic [CNT_W-1:0]      word_base;
   logic [CNT_W:0]        next_base;
   logic                  last_word;
   logic                  out_free;

   assign count = (32'(slots_ff) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(slots_ff);
   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         size_ff  <= SIZE_W'(1);
         slots_ff <= COUNT_W'(256);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BASE_ADDRESS: base_ff  <= csr_write_data;
            CSR_ELEMENT_SIZE: size_ff  <= csr_write_data[SIZE_W-1:0];
            CSR_SLOTS_IN_USE: slots_ff <= csr_write_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign div_start = accept && (req_cmd == CMD_FREE_ADDR) && (size_ff != '0)
                      && (req_element_address >= base_ff);

   bsa_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_element_address - base_ff),
      .divisor  (size_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign cur_word  = rd_valid_ff ? rd_data_ff : '0;
   assign bit_sel   = idx_ff[BIT_W-1:0];
   assign word_base = CNT_W'(word_ff) << BIT_W;
   assign next_base = (CNT_W+1)'(word_base) + (CNT_W+1)'(WORD_W);
   assign last_word = (word_ff == WADDR_W'(NUM_WORDS - 1)) ||
                      (next_base >= (CNT_W+1)'(count));

   always_comb begin
      for (int b = 0; b < WORD_W; b++) begin
         free_bits[b] = !cur_word[b] && ((word_base + CNT_W'(b)) < count);
      end
   end

   always_comb begin
      free_pos = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            free_pos = BIT_W'(b);
         end
      end
   end

   assign free_found = |free_bits;
   assign clear_all  = accept && (req_cmd == CMD_CLEAR);
   assign mem_re     = (state_ff == S_READ);

   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = cur_word;
      if (state_ff == S_CHECK) begin
         case (cmd_ff)
            CMD_ALLOC_FIRST: begin
               mem_we    = free_found;
               mem_wdata = cur_word | (WORD_W'(1) << free_pos);
            end
            CMD_ALLOC_INDEX: begin
               mem_we    = !cur_word[bit_sel];
               mem_wdata = cur_word | (WORD_W'(1) << bit_sel);
            end
            CMD_FREE_ADDR: begin
               mem_we    = 1'b1;
               mem_wdata = cur_word & ~(WORD_W'(1) << bit_sel);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[word_ff] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[word_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (clear_all) begin
            row_valid_ff <= '0;
         end else if (mem_we) begin
            row_valid_ff[word_ff] <= 1'b1;
         end
         if (mem_re) begin
            rd_valid_ff <= row_valid_ff[word_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cmd_ff    <= req_cmd;
                  status_ff <= ST_OK;
                  taken_ff  <= 1'b0;
                  gidx_ff   <= '0;
                  gaddr_ff  <= '0;
                  idx_ff    <= IDX_W'(req_slot_index);
                  word_ff   <= WADDR_W'(IDX_W'(req_slot_index) >> BIT_W);
                  case (req_cmd)
                     CMD_CLEAR: begin
                        state_ff <= S_DONE;
                     end
                     CMD_ALLOC_FIRST: begin
                        word_ff <= '0;
                        if (count == '0) begin
                           status_ff <= ST_FULL;
                           state_ff  <= S_DONE;
                        end else begin
                           state_ff <= S_READ;
                        end
                     end
                     CMD_ALLOC_INDEX, CMD_QUERY: begin
                        if (32'(req_slot_index) >= 32'(count)) begin
                           status_ff <= ST_RANGE;
                           state_ff  <= S_DONE;
                        end else begin
                           state_ff <= S_READ;
                        end
                     end
                     CMD_FREE_ADDR: begin
                        if (div_start) begin
                           state_ff <= S_DIV;
                        end else begin
                           status_ff <= ST_RANGE;
                           state_ff  <= S_DONE;
                        end
                     end
                     default: begin
                        status_ff <= ST_RANGE;
                        state_ff  <= S_DONE;
                     end
                  endcase
               end
            end
            S_DIV: begin
               if (div_done) begin
                  if (div_quotient >= ADDR_W'(count)) begin
                     status_ff <= ST_RANGE;
                     state_ff  <= S_DONE;
                  end else begin
                     idx_ff   <= div_quotient[IDX_W-1:0];
                     word_ff  <= WADDR_W'(div_quotient[IDX_W-1:0] >> BIT_W);
                     state_ff <= S_READ;
                  end
               end
            end
            S_READ: begin
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               case (cmd_ff)
                  CMD_ALLOC_FIRST: begin
                     if (free_found) begin
                        idx_ff   <= (IDX_W'(word_ff) << BIT_W) | IDX_W'(free_pos);
                        gidx_ff  <= (IDX_W'(word_ff) << BIT_W) | IDX_W'(free_pos);
                        state_ff <= S_MUL;
                     end else if (last_word) begin
                        status_ff <= ST_FULL;
                        state_ff  <= S_DONE;
                     end else begin
                        word_ff  <= word_ff + WADDR_W'(1);
                        state_ff <= S_READ;
                     end
                  end
                  CMD_ALLOC_INDEX: begin
                     if (cur_word[bit_sel]) begin
                        status_ff <= ST_BUSY;
                        state_ff  <= S_DONE;
                     end else begin
                        gidx_ff  <= idx_ff;
                        state_ff <= S_MUL;
                     end
                  end
                  CMD_QUERY: begin
                     taken_ff <= cur_word[bit_sel];
                     state_ff <= S_DONE;
                  end
                  default: begin
                     gidx_ff  <= idx_ff;
                     state_ff <= S_DONE;
                  end
               endcase
            end
            S_MUL: begin
               prod_ff  <= {{SIZE_W{1'b0}}, idx_ff} * {{IDX_W{1'b0}}, size_ff};
               state_ff <= S_ADD;
            end
            S_ADD: begin
               gaddr_ff <= base_ff + ADDR_W'(prod_ff);
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && out_free) begin
         rsp_status_ff <= status_ff;
         rsp_taken_ff  <= taken_ff;
         rsp_gidx_ff   <= SIDX_W'(gidx_ff);
         rsp_gaddr_ff  <= gaddr_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_slot_taken      = rsp_taken_ff;
   assign rsp_granted_index   = rsp_gidx_ff;
   assign rsp_granted_address = rsp_gaddr_ff;

endmodule

`default_nettype wire

[bench/bitmap_slot_allocator_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_slot_allocator_core: directed and random command
// traffic with random stalls on both channels, checked against an in-bench bitmap model.
// Depends on bsa_pkg and the core RTL.

module bitmap_slot_allocator_core_tb
   import bsa_pkg::*;
();

   localparam logic [CMD_W-1:0] CMD_RESERVED_LO  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_RESERVED_MID = 3'd6;
   localparam logic [CMD_W-1:0] CMD_RESERVED_HI  = 3'd7;
   localparam int MAX_WAIT      = 11;
   localparam int DRAIN_CYCLES  = 48;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 45;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [SIDX_W-1:0] slot;
      logic [ADDR_W-1:0] addr;
   } command_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                taken;
      logic [SIDX_W-1:0]   index;
      logic [ADDR_W-1:0]   address;
   } outcome_type;

   logic                 clock               = 1'b0;
   logic                 reset               = 1'b1;
   logic                 req_valid           = 1'b0;
   logic                 req_ready;
   logic [CMD_W-1:0]     req_cmd             = CMD_CLEAR;
   logic [SIDX_W-1:0]    req_slot_index      = '0;
   logic [ADDR_W-1:0]    req_element_address = '0;
   logic                 rsp_valid;
   logic                 rsp_ready           = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 rsp_slot_taken;
   logic [SIDX_W-1:0]    rsp_granted_index;
   logic [ADDR_W-1:0]    rsp_granted_address;
   logic                 csr_write_enable    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index           = CSR_BASE_ADDRESS;
   logic [ADDR_W-1:0]    csr_write_data      = '0;

   logic [MAX_SLOTS-1:0] occupancy_bits = '0;
   logic [ADDR_W-1:0]    base_reg       = '0;
   logic [SIZE_W-1:0]    size_reg       = 16'd1;
   logic [COUNT_W-1:0]   count_reg      = 9'd256;

   command_type command_queue[$];
   outcome_type outcome_queue[$];
   command_type next_command;
   command_type seen_command;

   int   queued_count   = 0;
   int   accepted_count = 0;
   int   mismatch_count = 0;
   int   cycle_count    = 0;
   int   req_wait       = 0;
   int   rsp_wait       = 0;
   int   req_wait_max   = MAX_WAIT;
   int   rsp_wait_max   = MAX_WAIT;
   logic req_fire       = 1'b0;
   logic rsp_fire       = 1'b0;

   bitmap_slot_allocator_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_slot_index      (req_slot_index),
      .req_element_address (req_element_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_slot_taken      (rsp_slot_taken),
      .rsp_granted_index   (rsp_granted_index),
      .rsp_granted_address (rsp_granted_address),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always #1 clock = ~clock;

   function automatic int managed_slots();
      return (count_reg > MAX_SLOTS) ? MAX_SLOTS : int'(count_reg);
   endfunction

   function automatic logic [ADDR_W-1:0] slot_address(input int idx);
      return base_reg + ADDR_W'(idx) * ADDR_W'(size_reg);
   endfunction

   function automatic int stall_cycles(input int limit);
      if (limit == 0 || $urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, limit);
   endfunction

   task automatic apply_command(input command_type c);
      outcome_type       o;
      int                n;
      logic [ADDR_W-1:0] offset;
      o = '0;
      n = managed_slots();
      case (c.cmd)
         CMD_CLEAR: occupancy_bits = '0;
         CMD_ALLOC_FIRST: begin
            o.status = ST_FULL;
            for (int i = 0; i < n; i++) begin
               if (!occupancy_bits[i]) begin
                  occupancy_bits[i] = 1'b1;
                  o.status  = ST_OK;
                  o.index   = SIDX_W'(i);
                  o.address = slot_address(i);
                  break;
               end
            end
         end
         CMD_ALLOC_INDEX: begin
            if (int'(c.slot) >= n) begin
               o.status = ST_RANGE;
            end else if (occupancy_bits[c.slot]) begin
               o.status = ST_BUSY;
            end else begin
               occupancy_bits[c.slot] = 1'b1;
               o.index   = c.slot;
               o.address = slot_address(int'(c.slot));
            end
         end
         CMD_QUERY: begin
            if (int'(c.slot) >= n)
               o.status = ST_RANGE;
            else
               o.taken = occupancy_bits[c.slot];
         end
         CMD_FREE_ADDR: begin
            if (size_reg == '0 || c.addr < base_reg) begin
               o.status = ST_RANGE;
            end else begin
               offset = (c.addr - base_reg) / ADDR_W'(size_reg);
               if (offset >= ADDR_W'(n)) begin
                  o.status = ST_RANGE;
               end else begin
                  occupancy_bits[offset] = 1'b0;
                  o.index = offset[SIDX_W-1:0];
               end
            end
         end
         default: o.status = ST_RANGE;
      endcase
      outcome_queue.push_back(o);
   endtask

   task automatic check_outcome();
      outcome_type want;
      if (outcome_queue.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("unexpected response: status %0d taken %0d index %0d address %h",
                     rsp_status, rsp_slot_taken, rsp_granted_index, rsp_granted_address);
      end else begin
         want = outcome_queue.pop_front();
         if (rsp_status !== want.status || rsp_slot_taken !== want.taken ||
             rsp_granted_index !== want.index || rsp_granted_address !== want.address) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("mismatch: status %0d/%0d taken %0d/%0d index %0d/%0d address %h/%h",
                        want.status, rsp_status, want.taken, rsp_slot_taken,
                        want.index, rsp_granted_index, want.address, rsp_granted_address);
         end
      end
   endtask

   // check responses before predicting, so a response never matches its own transaction
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         rsp_fire <= rsp_valid && rsp_ready;
         if (rsp_valid && rsp_ready)
            check_outcome();
         if (req_valid && req_ready) begin
            seen_command = '{req_cmd, req_slot_index, req_element_address};
            apply_command(seen_command);
            accepted_count <= accepted_count + 1;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_wait > 0) begin
            req_valid <= 1'b0;
            req_wait--;
         end else if (command_queue.size() != 0) begin
            next_command = command_queue.pop_front();
            req_cmd             <= next_command.cmd;
            req_slot_index      <= next_command.slot;
            req_element_address <= next_command.addr;
            req_valid           <= 1'b1;
            req_wait = stall_cycles(req_wait_max);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_fire)
            rsp_wait = stall_cycles(rsp_wait_max);
         if (rsp_wait > 0) begin
            rsp_ready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bitmap_slot_allocator_core verification failed");
         $finish;
      end
   end

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [ADDR_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_BASE_ADDRESS: base_reg  = data;
         CSR_ELEMENT_SIZE: size_reg  = data[SIZE_W-1:0];
         CSR_SLOTS_IN_USE: count_reg = data[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic queue_command(input logic [CMD_W-1:0] cmd, input logic [SIDX_W-1:0] slot,
                                input logic [ADDR_W-1:0] addr);
      command_queue.push_back('{cmd, slot, addr});
      queued_count++;
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (accepted_count != queued_count || outcome_queue.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic random_config();
      logic [ADDR_W-1:0] b;
      logic [ADDR_W-1:0] s;
      logic [ADDR_W-1:0] n;
      case ($urandom_range(0, 3))
         0: b = '0;
         1: b = '1;
         default: b = $urandom;
      endcase
      s = $urandom;
      case ($urandom_range(0, 7))
         0: s[SIZE_W-1:0] = '0;
         1: s[SIZE_W-1:0] = 16'd1;
         2: s[SIZE_W-1:0] = 16'hFFFF;
         3: s[SIZE_W-1:0] = SIZE_W'($urandom_range(1, 65535));
         default: s[SIZE_W-1:0] = SIZE_W'($urandom_range(1, 64));
      endcase
      n = $urandom;
      case ($urandom_range(0, 7))
         0: n[COUNT_W-1:0] = '0;
         1: n[COUNT_W-1:0] = 9'd1;
         2: n[COUNT_W-1:0] = 9'd256;
         3: n[COUNT_W-1:0] = 9'd511;
         4: n[COUNT_W-1:0] = COUNT_W'($urandom_range(257, 511));
         default: n[COUNT_W-1:0] = COUNT_W'($urandom_range(2, 40));
      endcase
      write_register(CSR_BASE_ADDRESS, b);
      write_register(CSR_ELEMENT_SIZE, s);
      write_register(CSR_SLOTS_IN_USE, n);
   endtask

   task automatic random_command();
      int                n;
      int                hot;
      int                pick;
      logic [SIDX_W-1:0] s;
      logic [ADDR_W-1:0] a;
      n    = managed_slots();
      hot  = (n == 0) ? 0 : ((n > 48) ? 47 : n - 1);
      pick = $urandom_range(0, 9);
      if (n == 0 || pick == 0)
         s = SIDX_W'($urandom);
      else if (pick == 1)
         s = SIDX_W'((n == MAX_SLOTS) ? n - 1 : n);
      else
         s = SIDX_W'($urandom_range(0, hot));
      a = slot_address(int'(s));
      if (size_reg != '0)
         a = a + ADDR_W'($urandom_range(0, int'(size_reg) - 1));
      pick = $urandom_range(0, 99);
      if (pick < 30)
         queue_command(CMD_ALLOC_FIRST, SIDX_W'($urandom), $urandom);
      else if (pick < 45)
         queue_command(CMD_ALLOC_INDEX, s, $urandom);
      else if (pick < 60)
         queue_command(CMD_QUERY, s, $urandom);
      else if (pick < 85)
         queue_command(CMD_FREE_ADDR, SIDX_W'($urandom), a);
      else if (pick < 88)
         queue_command(CMD_CLEAR, SIDX_W'($urandom), $urandom);
      else if (pick < 90)
         queue_command(CMD_W'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI)),
                       SIDX_W'($urandom), $urandom);
      else
         queue_command(CMD_W'($urandom), SIDX_W'($urandom), $urandom);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      @(posedge clock);
      queue_command(CMD_QUERY, 8'd0, '0);
      queue_command(CMD_ALLOC_FIRST, '0, '0);
      queue_command(CMD_ALLOC_FIRST, '1, '1);
      queue_command(CMD_ALLOC_INDEX, 8'd255, '0);
      queue_command(CMD_ALLOC_INDEX, 8'd255, '1);
      queue_command(CMD_QUERY, 8'd255, '0);
      queue_command(CMD_FREE_ADDR, '0, 32'd1);
      queue_command(CMD_FREE_ADDR, '0, 32'd1);
      queue_command(CMD_FREE_ADDR, '1, '1);
      queue_command(CMD_CLEAR, '1, '1);
      queue_command(CMD_QUERY, 8'd255, '0);
      queue_command(CMD_RESERVED_LO, '1, '1);
      queue_command(CMD_RESERVED_MID, '0, '0);
      queue_command(CMD_RESERVED_HI, '1, '0);
      wait_idle();

      // wrap the slot address past 2^32 and run a three-slot table full
      write_register(CSR_BASE_ADDRESS, 32'hFFFF_FF00);
      write_register(CSR_ELEMENT_SIZE, 32'h0000_FFFF);
      write_register(CSR_SLOTS_IN_USE, 32'd3);
      @(posedge clock);
      repeat (4) queue_command(CMD_ALLOC_FIRST, '0, '0);
      queue_command(CMD_ALLOC_INDEX, 8'd3, '0);
      queue_command(CMD_QUERY, 8'd3, '0);
      queue_command(CMD_FREE_ADDR, '0, '0);
      queue_command(CMD_FREE_ADDR, '0, '1);
      queue_command(CMD_ALLOC_INDEX, 8'd0, '0);
      wait_idle();

      // zero size and zero count
      write_register(CSR_ELEMENT_SIZE, '0);
      write_register(CSR_SLOTS_IN_USE, '0);
      @(posedge clock);
      queue_command(CMD_ALLOC_FIRST, '0, '0);
      queue_command(CMD_ALLOC_INDEX, 8'd0, '0);
      queue_command(CMD_QUERY, 8'd0, '0);
      queue_command(CMD_FREE_ADDR, '0, 32'hFFFF_FF00);
      wait_idle();

      // fill the full-depth table, punch two holes and refill them
      write_register(CSR_BASE_ADDRESS, $urandom);
      write_register(CSR_ELEMENT_SIZE, ADDR_W'($urandom_range(1, 65535)));
      write_register(CSR_SLOTS_IN_USE, 32'd256);
      @(posedge clock);
      req_wait_max = 0;
      rsp_wait_max = 3;
      queue_command(CMD_CLEAR, '0, '0);
      repeat (MAX_SLOTS + 1) queue_command(CMD_ALLOC_FIRST, SIDX_W'($urandom), $urandom);
      queue_command(CMD_FREE_ADDR, '0, slot_address(200) + ADDR_W'(size_reg - 1'b1));
      queue_command(CMD_FREE_ADDR, '0, slot_address(17));
      queue_command(CMD_ALLOC_FIRST, '0, '0);
      queue_command(CMD_ALLOC_FIRST, '0, '0);
      queue_command(CMD_ALLOC_FIRST, '0, '0);
      queue_command(CMD_ALLOC_INDEX, 8'd200, '0);
      queue_command(CMD_QUERY, 8'd255, '0);
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         random_config();
         @(posedge clock);
         req_wait_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_WAIT;
         rsp_wait_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_WAIT;
         repeat (PHASE_ITEMS) random_command();
         wait_idle();
      end

      if (mismatch_count == 0)
         $display("bitmap_slot_allocator_core verification clean");
      else
         $display("bitmap_slot_allocator_core verification failed");
      $finish;
   end

endmodule
